### hw/rtl/tlw_pkg.sv
package tlw_pkg;

    localparam int unsigned CharW  = 8;
    localparam int unsigned QDepth = 4;
    localparam int unsigned QPtrW  = $clog2(QDepth);

    localparam logic [CharW-1:0] ChNewline   = 8'h0A;
    localparam logic [CharW-1:0] ChSpace     = 8'h20;
    localparam logic [CharW-1:0] ChDash      = 8'h2D;
    localparam logic [CharW-1:0] WideLimit   = 8'd25;
    localparam logic [CharW-1:0] EarlyMargin = 8'd12;
    localparam logic [CharW-1:0] WidthReset  = 8'd80;

    // register byte addresses
    localparam logic [2:0] AddrLineWidth = 3'd0;

    typedef struct packed {
        logic [CharW-1:0] in_char;
        logic             end_of_text;
    } t_in_item;

    typedef struct packed {
        logic [CharW-1:0] out_char;
        logic             last_of_run;
    } t_out_item;

    // one classified item: a byte, optionally followed by '-' and newline
    typedef struct packed {
        logic [CharW-1:0] ch;
        logic             brk;
    } t_cmd;

    typedef enum logic [1:0] {
        PH_CHAR,
        PH_DASH,
        PH_NL
    } t_phase;

endpackage

### hw/rtl/tlw_front.sv
module tlw_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [7:0]         i_line_width,
    input  logic               i_accept,
    input  tlw_pkg::t_in_item  i_item,
    output tlw_pkg::t_cmd      o_cmd
);
    import tlw_pkg::*;

    logic [CharW-1:0] r_count;
    logic [CharW-1:0] n_count;
    logic [CharW-1:0] early;
    logic [CharW-1:0] cur;
    logic [CharW:0]   cur_inc;
    logic             space_brk;
    logic             force_brk;

    assign early = (i_line_width > WideLimit) ? (i_line_width - EarlyMargin)
                                              : {1'b0, i_line_width[CharW-1:1]};

    always_comb begin
        cur       = (i_item.in_char == ChNewline) ? '0 : r_count;
        cur_inc   = {1'b0, cur} + {{CharW{1'b0}}, 1'b1};
        space_brk = (i_item.in_char == ChSpace) && (early <= cur);
        // count >= width - 1, written without going negative
        force_brk = !space_brk && (cur_inc >= {1'b0, i_line_width});

        o_cmd.ch  = i_item.in_char;
        o_cmd.brk = 1'b0;
        n_count   = cur_inc[CharW-1:0];
        if (i_item.end_of_text) begin
            o_cmd.ch = ChNewline;
            n_count  = '0;
        end else if (space_brk) begin
            o_cmd.ch = ChNewline;
            n_count  = '0;
        end else if (force_brk) begin
            o_cmd.brk = 1'b1;
            n_count   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_accept) begin
            r_count <= n_count;
        end
    end

endmodule

### hw/rtl/tlw_queue.sv
module tlw_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr,
    input  tlw_pkg::t_cmd i_wr_cmd,
    output logic          o_full,
    input  logic          i_rd,
    output tlw_pkg::t_cmd o_rd_cmd,
    output logic          o_empty
);
    import tlw_pkg::*;

    t_cmd             r_mem [QDepth];
    logic [QPtrW-1:0] r_wr_ptr;
    logic [QPtrW-1:0] r_rd_ptr;
    logic [QPtrW:0]   r_fill;
    logic             wr_en;
    logic             rd_en;

    assign o_full   = (r_fill == (QPtrW+1)'(QDepth));
    assign o_empty  = (r_fill == '0);
    assign o_rd_cmd = r_mem[r_rd_ptr];
    assign wr_en    = i_wr && !o_full;
    assign rd_en    = i_rd && !o_empty;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_fill <= r_fill + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

endmodule

### hw/rtl/tlw_back.sv
module tlw_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_empty,
    input  tlw_pkg::t_cmd      i_q_cmd,
    output logic               o_q_rd,
    output logic               o_empty,
    input  logic               i_pop,
    output tlw_pkg::t_out_item o_item
);
    import tlw_pkg::*;

    t_phase    r_phase;
    t_phase    n_phase;
    logic      r_valid;
    t_out_item r_item;
    t_out_item n_item;
    logic      load;

    assign load    = !i_q_empty && (!r_valid || i_pop);
    assign o_empty = !r_valid;
    assign o_item  = r_item;

    always_comb begin
        n_phase = r_phase;
        o_q_rd  = 1'b0;
        n_item  = '{out_char: i_q_cmd.ch, last_of_run: !i_q_cmd.brk};
        case (r_phase)
            PH_CHAR: begin
                if (load) begin
                    if (i_q_cmd.brk) begin
                        n_phase = PH_DASH;
                    end else begin
                        o_q_rd = 1'b1;
                    end
                end
            end
            PH_DASH: begin
                n_item = '{out_char: ChDash, last_of_run: 1'b0};
                if (load) begin
                    n_phase = PH_NL;
                end
            end
            PH_NL: begin
                n_item = '{out_char: ChNewline, last_of_run: 1'b1};
                if (load) begin
                    n_phase = PH_CHAR;
                    o_q_rd  = 1'b1;
                end
            end
            default: begin
                n_phase = PH_CHAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_CHAR;
            r_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            if (load) begin
                r_valid <= 1'b1;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item <= n_item;
        end
    end

endmodule

### hw/rtl/text_line_wrapper.sv
// text line wrapper: inserts line breaks into a byte stream
// input channel: push/full queue interface, one item (a byte or an end marker)
//   per transfer; an item is taken at an edge with push high and full low
// result channel: empty/pop queue interface; the oldest result sits on
//   o_out_item while empty is low and is taken at an edge with pop high
// each input gives one result byte, or three (byte, '-', newline) when the
//   byte lands on the last column; last_of_run marks the final one
// the first result of an item is registered in the command queue, then in the
//   output register once that register is free
// throughput: one input item per cycle while full is low; three-byte runs hold
//   the single output register for all three result bytes, so a run of them
//   fills the four-entry command queue and raises full
// reset (synchronous, active low): column count cleared, queue and output
//   emptied, line_width back to 80
// when the receiver holds pop low, results wait in the output register and
//   the queue; input keeps flowing until the queue is full
// line_width is written over the APB port; the user must do so only while the block is idle (not enforced)
module text_line_wrapper (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input queue side
    input  logic               push,
    output logic               full,
    input  tlw_pkg::t_in_item  i_in_item,
    // result queue side
    output logic               empty,
    input  logic               pop,
    output tlw_pkg::t_out_item o_out_item,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import tlw_pkg::*;

    logic [CharW-1:0] r_line_width;
    logic             cfg_wr;
    logic             in_accept;
    t_cmd             front_cmd;
    t_cmd             q_cmd;
    logic             q_empty;
    logic             q_rd;

    // register file: line_width at byte address 0
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr == AddrLineWidth) ? {{(32-CharW){1'b0}}, r_line_width} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= WidthReset;
        end else if (cfg_wr && (paddr == AddrLineWidth)) begin
            r_line_width <= pwdata[CharW-1:0];
        end
    end

    // front: classify each byte against the column count
    assign in_accept = push && !full;

    tlw_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_line_width (r_line_width),
        .i_accept     (in_accept),
        .i_item       (i_in_item),
        .o_cmd        (front_cmd)
    );

    // command queue decouples classification from result expansion
    tlw_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (push),
        .i_wr_cmd (front_cmd),
        .o_full   (full),
        .i_rd     (q_rd),
        .o_rd_cmd (q_cmd),
        .o_empty  (q_empty)
    );

    // back: expand each command into one or three result transfers
    tlw_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_cmd   (q_cmd),
        .o_q_rd    (q_rd),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_item    (o_out_item)
    );

endmodule

### verif/tlw_stream_checker.sv
`timescale 1ns / 100ps

module tlw_stream_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic               i_full,
    input  tlw_pkg::t_in_item  i_in_item,
    input  logic               i_empty,
    input  logic               i_pop,
    input  tlw_pkg::t_out_item i_out_item,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic [2:0]         i_paddr,
    input  logic [31:0]        i_pwdata,
    input  logic               i_pready,
    output int                 o_fail_count,
    output int                 o_pending
);
    import tlw_pkg::*;

    logic [CharW-1:0] width_q;
    logic [CharW-1:0] col_q;
    t_out_item        exp_chars [$];
    int               fails;

    initial begin
        fails        = 0;
        o_fail_count = 0;
        o_pending    = 0;
        width_q      = WidthReset;
        col_q        = '0;
    end

    // expected output bytes for one accepted input item
    function automatic void predict_wrap(input t_in_item it);
        t_out_item r;
        int        w;
        int        early;
        int        cnt;
        r = '0;
        // an 8-bit width never exceeds the 255 limit, so no clamp is needed
        w = int'(width_q);
        early = (w > int'(WideLimit)) ? w - int'(EarlyMargin) : w / 2;
        if (it.end_of_text) begin
            r.out_char    = ChNewline;
            r.last_of_run = 1'b1;
            exp_chars.push_back(r);
            col_q = '0;
            return;
        end
        cnt = (it.in_char == ChNewline) ? 0 : int'(col_q);
        if (it.in_char == ChSpace && early <= cnt) begin
            r.out_char    = ChNewline;
            r.last_of_run = 1'b1;
            exp_chars.push_back(r);
            cnt = 0;
        end else if (w - 1 <= cnt) begin
            r.out_char = it.in_char;
            exp_chars.push_back(r);
            r.out_char = ChDash;
            exp_chars.push_back(r);
            r.out_char    = ChNewline;
            r.last_of_run = 1'b1;
            exp_chars.push_back(r);
            cnt = 0;
        end else begin
            r.out_char    = it.in_char;
            r.last_of_run = 1'b1;
            exp_chars.push_back(r);
            cnt = cnt + 1;
        end
        col_q = cnt[CharW-1:0];
    endfunction

    always @(posedge i_clk) begin : watch
        t_out_item want;
        if (!i_rst_n) begin
            width_q = WidthReset;
            col_q   = '0;
            exp_chars.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == AddrLineWidth) begin
                width_q = i_pwdata[CharW-1:0];
            end
            // result side first: a result never stems from an item taken at the same edge
            if (i_pop && !i_empty) begin
                if (exp_chars.size() == 0) begin
                    $error("unexpected result: out_char %h last_of_run %b",
                           i_out_item.out_char, i_out_item.last_of_run);
                    fails++;
                end else begin
                    want = exp_chars.pop_front();
                    if (i_out_item.out_char !== want.out_char) begin
                        $error("out_char: expected %h, actual %h",
                               want.out_char, i_out_item.out_char);
                        fails++;
                    end
                    if (i_out_item.last_of_run !== want.last_of_run) begin
                        $error("last_of_run: expected %b, actual %b",
                               want.last_of_run, i_out_item.last_of_run);
                        fails++;
                    end
                end
            end
            if (i_push && !i_full) begin
                predict_wrap(i_in_item);
            end
        end
        o_pending    <= exp_chars.size();
        o_fail_count <= fails;
    end

endmodule

### verif/tb_text_line_wrapper.sv
`timescale 1ns / 100ps

module tb_text_line_wrapper;
    import tlw_pkg::*;

    localparam int HoldCycles = 60;        // long receiver hold-off
    localparam int PhaseItems = 19;        // random items per width setting
    localparam int NumPhases  = 8;
    localparam int TimeoutNs  = 4_000_000;  // far above the slowest correct run

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;

    // input transfer side
    logic        push    = 1'b0;
    logic        full;
    t_in_item    in_item = '0;

    // result transfer side
    logic        empty;
    logic        pop     = 1'b0;
    t_out_item   out_item;

    // configuration port
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    int          fail_count;
    int          pending;

    // shared between the stimulus and the receiver process
    bit          hold_req = 1'b0;
    bit          quiet    = 1'b0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    text_line_wrapper uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in_item  (in_item),
        .empty      (empty),
        .pop        (pop),
        .o_out_item (out_item),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    tlw_stream_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_in_item    (in_item),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_out_item   (out_item),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // offer one item from the current edge on, return at the edge of its transfer
    task automatic send_item(input t_in_item it);
        push    <= 1'b1;
        in_item <= it;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
    endtask

    task automatic send_char(input logic [CharW-1:0] ch);
        t_in_item it;
        it.in_char     = ch;
        it.end_of_text = 1'b0;
        send_item(it);
    endtask

    task automatic send_end(input logic [CharW-1:0] junk);
        t_in_item it;
        it.in_char     = junk;
        it.end_of_text = 1'b1;
        send_item(it);
    endtask

    // random gap on the sender side, none in the calm last part
    task automatic sender_gap();
        if (!quiet && $urandom_range(0, 4) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
    endtask

    // wait until every expected result has been taken
    // pending is registered and trails the checker queue, so wait for an edge first
    task automatic wait_drained();
        do @(posedge i_clk); while (pending != 0);
    endtask

    // line_width write while idle: setup cycle, then access cycle
    task automatic set_width(input logic [CharW-1:0] w);
        push <= 1'b0;
        wait_drained();
        // let the pipeline settle
        repeat (4) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= AddrLineWidth;
        // upper bits are junk that the register drops
        pwdata  <= {24'($urandom() >> 8), w};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // text-like random item: mostly letters and spaces, some newlines,
    // end markers and arbitrary bytes
    function automatic t_in_item rand_text_item();
        t_in_item it;
        int       pick;
        pick = $urandom_range(0, 99);
        it.end_of_text = 1'b0;
        if (pick < 55) begin
            it.in_char = 8'h61 + 8'($urandom_range(0, 25));
        end else if (pick < 75) begin
            it.in_char = ChSpace;
        end else if (pick < 80) begin
            it.in_char = ChNewline;
        end else if (pick < 85) begin
            it.in_char     = 8'($urandom());
            it.end_of_text = 1'b1;
        end else begin
            it.in_char = 8'($urandom());
        end
        return it;
    endfunction

    // receiver: random pop bursts, a long hold-off on request, steady pop when calm
    initial begin : receiver
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HoldCycles;
            end
            if (hold_left > 0) begin
                pop <= 1'b0;
                hold_left--;
            end else if (quiet) begin
                pop <= 1'b1;
            end else if (stall_left > 0) begin
                pop <= 1'b0;
                stall_left--;
            end else if ($urandom_range(0, 5) == 0) begin
                pop <= 1'b0;
                stall_left = $urandom_range(1, 13) - 1;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        logic [CharW-1:0] widths [NumPhases];
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: byte extremes at the reset width of 80
        send_char(8'h00);
        send_char(8'hFF);
        send_char(ChDash);
        send_end(8'hFF);  // byte on an end marker is ignored

        // narrow width 4: early break at 2, last column at 3
        set_width(8'd4);
        send_char("a");
        send_char("b");
        send_char("c");
        send_char("d");      // lands on the last column: byte, dash, newline
        send_char("a");
        send_char(ChSpace);  // before the early break point: passes
        send_char(ChSpace);  // at the early break point: becomes newline
        send_char(ChNewline);
        send_end(8'h00);

        // width 1: an input newline itself is forced to break
        set_width(8'd1);
        send_char(ChNewline);
        send_char(ChSpace);
        send_char("z");

        // zero width: spaces turn into newlines, all else breaks
        set_width(8'd0);
        send_char(ChSpace);
        send_char("q");

        // width lowered mid-line: count left above the new limit
        set_width(8'd10);
        send_char("a");
        send_char("b");
        send_char("c");
        set_width(8'd2);
        send_char("y");

        // random part over several width settings, extremes included
        widths[0] = 8'd255;
        widths[1] = 8'd12;
        widths[2] = 8'd1;
        widths[3] = 8'd26;  // just above the wide threshold
        widths[4] = 8'd25;  // at the wide threshold
        widths[5] = 8'd0;
        widths[6] = 8'($urandom_range(2, 40));
        widths[7] = 8'($urandom_range(1, 255));
        for (int p = 0; p < NumPhases; p++) begin
            set_width(widths[p]);
            if (p == NumPhases - 1) begin
                quiet = 1'b1;
            end
            if (p == 1) begin
                // receiver stops while items keep coming, so full must rise
                hold_req = 1'b1;
            end
            for (int k = 0; k < PhaseItems; k++) begin
                send_item(rand_text_item());
                if (p == 3 && k == PhaseItems / 2) begin
                    // sender pauses until the block has fully drained
                    push <= 1'b0;
                    wait_drained();
                end else begin
                    sender_gap();
                end
            end
        end

        push <= 1'b0;
        wait_drained();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin : watchdog
        #(TimeoutNs);
        $display("FAILURE");
        $finish;
    end

endmodule
